// File: rtl/iee_pkg.sv
// Shared types and constants for the infix expression evaluator.
package iee_pkg;

  localparam int VALUE_WIDTH     = 32;
  localparam int OUT_WIDTH       = 32;
  localparam int CMD_QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_SLASH = 8'h2f;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_WIDTH-1:0] value;
    logic                        div_by_zero;
  } out_item_t;

  typedef enum logic [1:0] {
    K_DIGIT,
    K_ADDSUB,
    K_MULDIV,
    K_SKIP
  } kind_t;

  // classified item; alt selects minus for add/sub and divide for mul/div
  typedef struct packed {
    kind_t      kind;
    logic [3:0] digit;
    logic       alt;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic                   done;
    logic                   dz;
    logic [VALUE_WIDTH-1:0] quotient;
  } div_res_t;

endpackage

// File: rtl/iee_front.sv
// Front end: classifies incoming characters and pushes commands into the queue.
module iee_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  iee_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              q_push,
  output iee_pkg::cmd_t     q_cmd
);

  logic [7:0] ch;

  assign ch = in_data.char_code;

  always_comb begin
    q_cmd       = '0;
    q_cmd.kind  = iee_pkg::K_SKIP;
    q_cmd.last  = in_data.is_last;
    q_cmd.digit = 4'(ch - iee_pkg::CH_0);
    if (ch >= iee_pkg::CH_0 && ch <= iee_pkg::CH_9) begin
      q_cmd.kind = iee_pkg::K_DIGIT;
    end else if (ch == iee_pkg::CH_PLUS || ch == iee_pkg::CH_MINUS) begin
      q_cmd.kind = iee_pkg::K_ADDSUB;
      q_cmd.alt  = (ch == iee_pkg::CH_MINUS);
    end else if (ch == iee_pkg::CH_STAR || ch == iee_pkg::CH_SLASH) begin
      q_cmd.kind = iee_pkg::K_MULDIV;
      q_cmd.alt  = (ch == iee_pkg::CH_SLASH);
    end
  end

  assign in_ready = !q_full;
  // ignored characters are dropped here unless they end the expression
  assign q_push   = in_valid && !q_full &&
                    (q_cmd.kind != iee_pkg::K_SKIP || in_data.is_last);

endmodule

// File: rtl/iee_fifo.sv
// Short command queue between the front end and the execution unit.
module iee_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  iee_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output iee_pkg::cmd_t pop_cmd,
  output logic          not_empty
);

  localparam int AW = $clog2(iee_pkg::CMD_QUEUE_DEPTH);
  localparam int CW = $clog2(iee_pkg::CMD_QUEUE_DEPTH + 1);

  iee_pkg::cmd_t  mem_r [iee_pkg::CMD_QUEUE_DEPTH];
  logic [AW-1:0]  wr_ptr_r;
  logic [AW-1:0]  rd_ptr_r;
  logic [CW-1:0]  count_r;
  logic           do_push;
  logic           do_pop;

  assign full      = (count_r == CW'(iee_pkg::CMD_QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_cmd   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(iee_pkg::CMD_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(iee_pkg::CMD_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// File: rtl/iee_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module iee_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [iee_pkg::VALUE_WIDTH-1:0] dividend,
  input  logic [iee_pkg::VALUE_WIDTH-1:0] divisor,
  output iee_pkg::div_res_t               res
);

  localparam int VW = iee_pkg::VALUE_WIDTH;
  localparam int CW = $clog2(VW);

  typedef enum logic [1:0] {
    D_IDLE,
    D_RUN,
    D_DONE
  } div_state_t;

  div_state_t         state_r;
  logic [VW-1:0]      rem_r;
  logic [VW-1:0]      quo_r;
  logic [VW-1:0]      den_r;
  logic               neg_r;
  logic [CW-1:0]      cnt_r;
  iee_pkg::div_res_t  res_r;
  logic [VW-1:0]      mag_a;
  logic [VW-1:0]      mag_b;
  logic [VW:0]        trial;

  assign mag_a = dividend[VW-1] ? (VW'(0) - dividend) : dividend;
  assign mag_b = divisor[VW-1]  ? (VW'(0) - divisor)  : divisor;
  assign trial = {rem_r, quo_r[VW-1]} - {1'b0, den_r};
  assign res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= D_IDLE;
      res_r.done <= 1'b0;
    end else begin
      case (state_r)
        D_IDLE: begin
          res_r.done <= 1'b0;
          if (start) begin
            neg_r <= dividend[VW-1] ^ divisor[VW-1];
            quo_r <= mag_a;
            den_r <= mag_b;
            rem_r <= '0;
            cnt_r <= '0;
            if (mag_b == '0) begin
              res_r.done     <= 1'b1;
              res_r.dz       <= 1'b1;
              res_r.quotient <= '0;
            end else begin
              state_r <= D_RUN;
            end
          end
        end
        D_RUN: begin
          if (!trial[VW]) begin
            rem_r <= trial[VW-1:0];
            quo_r <= {quo_r[VW-2:0], 1'b1};
          end else begin
            rem_r <= {rem_r[VW-2:0], quo_r[VW-1]};
            quo_r <= {quo_r[VW-2:0], 1'b0};
          end
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CW'(VW - 1)) begin
            state_r <= D_DONE;
          end
        end
        D_DONE: begin
          res_r.done     <= 1'b1;
          res_r.dz       <= 1'b0;
          res_r.quotient <= neg_r ? (VW'(0) - quo_r) : quo_r;
          state_r        <= D_IDLE;
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/iee_back.sv
// Execution unit: builds numbers, closes terms and sums, drives the result register.
module iee_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  output logic               cmd_pop,
  input  iee_pkg::cmd_t      cmd,
  output logic               out_valid,
  input  logic               out_ready,
  output iee_pkg::out_item_t out_data
);

  localparam int VW = iee_pkg::VALUE_WIDTH;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CLOSE,
    B_DIVW,
    B_POST,
    B_FIN
  } back_state_t;

  typedef enum logic [1:0] {
    P_NONE,
    P_MUL,
    P_DIV
  } pend_t;

  back_state_t        state_r;
  iee_pkg::cmd_t      cmd_r;
  logic [VW-1:0]      num_r;
  logic [VW-1:0]      term_r;
  logic [VW-1:0]      sum_r;
  pend_t              pend_r;
  logic               neg_r;
  logic               zds_r;
  logic               out_valid_r;
  iee_pkg::out_item_t out_data_r;
  logic [VW-1:0]      num_step;
  logic [VW-1:0]      sum_closed;
  logic               div_start;
  iee_pkg::div_res_t  div_res;

  // number*10 + digit as two shifted adds
  assign num_step   = (num_r << 3) + (num_r << 1) + {{(VW-4){1'b0}}, cmd.digit};
  assign sum_closed = neg_r ? (sum_r - term_r) : (sum_r + term_r);
  assign div_start  = (state_r == B_CLOSE) && (pend_r == P_DIV);
  assign cmd_pop    = (state_r == B_IDLE) && cmd_valid;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  iee_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (term_r),
    .divisor  (num_r),
    .res      (div_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      num_r       <= '0;
      term_r      <= '0;
      sum_r       <= '0;
      pend_r      <= P_NONE;
      neg_r       <= 1'b0;
      zds_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // in B_FIN an accepted item is replaced by the new one below
      if (out_valid_r && out_ready && state_r != B_FIN) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          if (cmd_valid) begin
            cmd_r <= cmd;
            if (cmd.kind == iee_pkg::K_DIGIT) begin
              num_r <= num_step;
              if (cmd.last) begin
                state_r <= B_CLOSE;
              end
            end else begin
              state_r <= B_CLOSE;
            end
          end
        end
        B_CLOSE: begin
          num_r <= '0;
          case (pend_r)
            P_MUL: begin
              term_r  <= term_r * num_r;
              state_r <= B_POST;
            end
            P_DIV:   state_r <= B_DIVW;
            default: begin
              term_r  <= num_r;
              state_r <= B_POST;
            end
          endcase
        end
        B_DIVW: begin
          if (div_res.done) begin
            term_r  <= div_res.quotient;
            zds_r   <= zds_r | div_res.dz;
            state_r <= B_POST;
          end
        end
        B_POST: begin
          case (cmd_r.kind)
            iee_pkg::K_ADDSUB: begin
              sum_r   <= sum_closed;
              term_r  <= '0;
              neg_r   <= cmd_r.alt;
              pend_r  <= P_NONE;
              state_r <= cmd_r.last ? B_FIN : B_IDLE;
            end
            iee_pkg::K_MULDIV: begin
              pend_r <= cmd_r.alt ? P_DIV : P_MUL;
              if (cmd_r.last) begin
                // operator ends the expression: close again with a zero operand
                cmd_r.kind <= iee_pkg::K_SKIP;
                state_r    <= B_CLOSE;
              end else begin
                state_r <= B_IDLE;
              end
            end
            default: begin
              sum_r   <= sum_closed;
              term_r  <= '0;
              state_r <= B_FIN;
            end
          endcase
        end
        B_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r            <= 1'b1;
            out_data_r.value       <= iee_pkg::OUT_WIDTH'($signed(sum_r));
            out_data_r.div_by_zero <= zds_r;
            num_r   <= '0;
            term_r  <= '0;
            sum_r   <= '0;
            pend_r  <= P_NONE;
            neg_r   <= 1'b0;
            zds_r   <= 1'b0;
            state_r <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/infix_expression_evaluator.sv
// Top level of the streaming infix expression evaluator.
//
//   channel  | direction | handshake            | payload
//   in_      | input     | in_valid / in_ready   | iee_pkg::in_item_t  (char_code, is_last)
//   out_     | output    | out_valid / out_ready | iee_pkg::out_item_t (value, div_by_zero)
//
// A digit is absorbed in B_IDLE; ignored characters reach the unit only as a last item.
// +, -, * and / pass through B_IDLE, B_CLOSE and B_POST, and when they close a division
// also wait in B_DIVW on the 32-step iterative divider, which skips a zero divisor.
// The result is loaded in B_FIN; a closing * or / first repeats B_CLOSE and B_POST.
// The front end keeps filling a 4-entry queue while the execution unit works, until full.
// The result register stalls only the execution unit; rst_n is synchronous, active low.
module infix_expression_evaluator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  iee_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output iee_pkg::out_item_t out_data
);

  logic          q_full;
  logic          q_push;
  iee_pkg::cmd_t q_cmd;
  logic          q_pop;
  iee_pkg::cmd_t q_head;
  logic          q_not_empty;

  iee_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  iee_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_cmd   (q_head),
    .not_empty (q_not_empty)
  );

  iee_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_not_empty),
    .cmd_pop   (q_pop),
    .cmd       (q_head),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: rtl/iee_checker.sv
// Port-level checks for the infix expression evaluator, bound to the top level.
module iee_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input iee_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input iee_pkg::out_item_t out_data
);

  // expressions whose last item was taken but whose result is not yet delivered
  logic [3:0] open_r;
  logic       last_in;
  logic       res_out;

  assign last_in = in_valid && in_ready && in_data.is_last;
  assign res_out = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= '0;
    end else begin
      case ({last_in, res_out})
        2'b10:   open_r <= open_r + 1'b1;
        2'b01:   open_r <= open_r - 1'b1;
        default: open_r <= open_r;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed or dropped while stalled");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> open_r != 4'd0)
    else $error("result item without a finished expression");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind infix_expression_evaluator iee_checker u_iee_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: sim/infix_expression_evaluator_tb.sv
// Self-checking testbench for the streaming infix expression evaluator.
module infix_expression_evaluator_tb;

  typedef enum logic [1:0] {MD_NONE, MD_MUL, MD_DIV} muldiv_t;

  typedef struct {
    iee_pkg::in_item_t item;
    bit                drain;  // hold this item back until every value has come out
  } char_slot_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  iee_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  iee_pkg::out_item_t out_data;

  char_slot_t         char_queue[$];
  iee_pkg::out_item_t awaited_values[$];

  // evaluator state mirrored by the predictor
  logic [31:0] num_acc = '0;
  logic [31:0] term_val = '0;
  logic [31:0] run_sum = '0;
  muldiv_t     pend_op = MD_NONE;
  bit          term_neg = 1'b0;
  bit          dz_seen = 1'b0;

  int chars_sent = 0;
  int values_predicted = 0;
  int values_checked = 0;
  int dz_values = 0;
  int expressions = 0;
  int mismatches = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  infix_expression_evaluator dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // fold the number being built into the open term
  function automatic void close_operand();
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic [31:0] quot;
    case (pend_op)
      MD_MUL: term_val = term_val * num_acc;
      MD_DIV: begin
        mag_a = term_val[31] ? -term_val : term_val;
        mag_b = num_acc[31] ? -num_acc : num_acc;
        if (mag_b == 0) begin
          dz_seen = 1'b1;
          quot = '0;
        end else begin
          quot = mag_a / mag_b;
          if (term_val[31] ^ num_acc[31]) quot = -quot;
        end
        term_val = quot;
      end
      default: term_val = num_acc;
    endcase
    num_acc = '0;
  endfunction

  function automatic void close_term();
    run_sum = term_neg ? run_sum - term_val : run_sum + term_val;
    term_val = '0;
  endfunction

  // returns 1 when the item completes an expression
  function automatic bit absorb_char(input iee_pkg::in_item_t it);
    logic [7:0]         c;
    iee_pkg::out_item_t res;
    c = it.char_code;
    if (c >= iee_pkg::CH_0 && c <= iee_pkg::CH_9) begin
      num_acc = num_acc * 32'd10 + {24'd0, c - iee_pkg::CH_0};
    end else if (c == iee_pkg::CH_PLUS || c == iee_pkg::CH_MINUS) begin
      close_operand();
      close_term();
      term_neg = (c == iee_pkg::CH_MINUS);
      pend_op = MD_NONE;
    end else if (c == iee_pkg::CH_STAR || c == iee_pkg::CH_SLASH) begin
      close_operand();
      pend_op = (c == iee_pkg::CH_STAR) ? MD_MUL : MD_DIV;
    end
    if (!it.is_last) return 1'b0;
    close_operand();
    close_term();
    res.value = run_sum;
    res.div_by_zero = dz_seen;
    awaited_values.push_back(res);
    if (dz_seen) dz_values++;
    num_acc = '0;
    term_val = '0;
    run_sum = '0;
    pend_op = MD_NONE;
    term_neg = 1'b0;
    dz_seen = 1'b0;
    return 1'b1;
  endfunction

  task automatic add_expression(input logic [7:0] text[$], input bit drain);
    char_slot_t s;
    foreach (text[i]) begin
      s.item.char_code = text[i];
      s.item.is_last = (i == text.size() - 1);
      s.drain = drain && (i == 0);
      char_queue.push_back(s);
    end
    expressions++;
  endtask

  task automatic add_text(input string s, input bit drain);
    logic [7:0] text[$];
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    add_expression(text, drain);
  endtask

  task automatic add_random_expression(input bit drain);
    logic [7:0] text[$];
    logic [7:0] ops[4];
    logic [7:0] noise;
    string      digits;
    int         terms;
    int         pick;
    ops = '{iee_pkg::CH_PLUS, iee_pkg::CH_MINUS, iee_pkg::CH_STAR, iee_pkg::CH_SLASH};
    if ($urandom_range(0, 99) < 10) begin
      // pure noise: any byte at all
      repeat ($urandom_range(1, 8)) text.push_back(8'($urandom));
    end else begin
      terms = $urandom_range(1, 6);
      for (int t = 0; t < terms; t++) begin
        if ($urandom_range(0, 99) < 5) begin
          do noise = 8'($urandom);
          while ((noise >= iee_pkg::CH_0 && noise <= iee_pkg::CH_9) ||
                 noise == iee_pkg::CH_PLUS || noise == iee_pkg::CH_MINUS ||
                 noise == iee_pkg::CH_STAR || noise == iee_pkg::CH_SLASH);
          text.push_back(noise);
        end
        pick = $urandom_range(0, 99);
        digits = "";
        if (pick < 8) begin
          // missing operand
        end else if (pick < 70) begin
          digits = $sformatf("%0d", $urandom_range(0, 12));
        end else if (pick < 92) begin
          digits = $sformatf("%0d", $urandom_range(0, 99999));
        end else begin
          // long numbers can wrap the accumulator
          repeat ($urandom_range(9, 12))
            text.push_back(iee_pkg::CH_0 + 8'($urandom_range(0, 9)));
        end
        for (int k = 0; k < digits.len(); k++) text.push_back(digits[k]);
        if (t != terms - 1) text.push_back(ops[$urandom_range(0, 3)]);
      end
      if ($urandom_range(0, 99) < 6 || text.size() == 0)
        text.push_back(ops[$urandom_range(0, 3)]);
    end
    add_expression(text, drain);
  endtask

  // driver
  always @(posedge clk) begin : drive_proc
    bit steady;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      if (in_valid && in_ready) begin
        if (absorb_char(in_data)) values_predicted <= values_predicted + 1;
        chars_sent <= chars_sent + 1;
      end
      if (!in_valid || in_ready) begin
        steady = chars_sent >= 900 && chars_sent < 1150;
        if (char_queue.size() != 0 && (steady || $urandom_range(0, 99) >= 14) &&
            !(char_queue[0].drain &&
              (awaited_values.size() != 0 || values_predicted != values_checked))) begin
          in_valid <= 1'b1;
          in_data <= char_queue[0].item;
          char_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and result-side ready
  always @(posedge clk) begin : check_proc
    iee_pkg::out_item_t want;
    bit                 steady;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_values.size() == 0) begin
          $display("%0t: unexpected value %0d div_by_zero %0b", $time,
                   out_data.value, out_data.div_by_zero);
          mismatches++;
        end else begin
          want = awaited_values.pop_front();
          if (out_data.value !== want.value) begin
            $display("%0t: value expected %0d actual %0d", $time, want.value,
                     out_data.value);
            mismatches++;
          end
          if (out_data.div_by_zero !== want.div_by_zero) begin
            $display("%0t: div_by_zero expected %0b actual %0b", $time,
                     want.div_by_zero, out_data.div_by_zero);
            mismatches++;
          end
        end
        values_checked <= values_checked + 1;
      end
      steady = chars_sent >= 900 && chars_sent < 1150;
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (!hold_done && chars_sent >= 600) begin
        // long back-pressure so the input side fills and stalls
        hold_done <= 1'b1;
        hold_left <= 400;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || $urandom_range(0, 99) >= 14;
      end
    end
  end

  initial begin
    add_text("0", 1'b0);
    add_text("2147483648/4294967295", 1'b0);  // minimum over -1 wraps
    add_text("7/0", 1'b1);
    add_text("-3", 1'b0);
    add_text("3-", 1'b0);
    add_text("2147483649/2", 1'b0);
    add_text("9*8-6/4", 1'b0);
    add_text("7*", 1'b0);
    add_text("/", 1'b0);
    add_text("1a+ 2", 1'b0);
    add_expression('{8'hff}, 1'b0);
    add_expression('{8'h00}, 1'b0);
    while (char_queue.size() < 1350) add_random_expression(expressions % 40 == 39);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (char_queue.size() != 0 || in_valid) @(posedge clk);
    while (awaited_values.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("%0d expressions in %0d characters; %0d values checked, %0d with a zero divisor",
             expressions, chars_sent, values_checked, dz_values);
    $display("covered wrap, min/-1, missing operands, skipped bytes and input back-pressure");
    if (mismatches == 0 && awaited_values.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0t: %0d values never arrived", $time, awaited_values.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: infix_expression_evaluator.f
rtl/iee_pkg.sv
rtl/iee_front.sv
rtl/iee_fifo.sv
rtl/iee_div.sv
rtl/iee_back.sv
rtl/infix_expression_evaluator.sv
rtl/iee_checker.sv
sim/infix_expression_evaluator_tb.sv
